### src/ctb_pkg.sv
package ctb_pkg;

	localparam int CAPACITY_DEF = 1024;

	localparam int OPCODE_W = 3;
	localparam int CHAR_W   = 8;
	localparam int POS_W    = 10;
	localparam int STATUS_W = 2;
	localparam int LEN_W    = 11;

	typedef enum logic [OPCODE_W-1:0] {
		OP_INSERT = 3'd0,
		OP_LEFT   = 3'd1,
		OP_RIGHT  = 3'd2,
		OP_BACK   = 3'd3,
		OP_READ   = 3'd4
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_EDGE  = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

endpackage

### src/ctb_cmd_if.sv
interface ctb_cmd_if;
	logic                            valid;
	logic                            ready;
	logic [ctb_pkg::OPCODE_W-1:0]    opcode;
	logic [ctb_pkg::CHAR_W-1:0]      char_in;
	logic [ctb_pkg::POS_W-1:0]       position;

	modport source(output valid, opcode, char_in, position, input ready);
	modport sink(input valid, opcode, char_in, position, output ready);
endinterface

### src/ctb_res_if.sv
interface ctb_res_if;
	logic                            valid;
	logic                            ready;
	logic [ctb_pkg::CHAR_W-1:0]      char_out;
	logic [ctb_pkg::STATUS_W-1:0]    status;
	logic [ctb_pkg::LEN_W-1:0]       text_length;
	logic [ctb_pkg::LEN_W-1:0]       cursor_index;

	modport source(output valid, char_out, status, text_length, cursor_index, input ready);
	modport sink(input valid, char_out, status, text_length, cursor_index, output ready);
endinterface

### src/cursor_text_buffer_unit.sv
// Gap-buffer text editor: the text left of the cursor and the text right of it are held
// as two byte stacks of CAPACITY entries each, with the character next to the cursor on
// top of either stack. One command request is taken in every clock cycle as long as the
// result side keeps up, and each gives exactly one result through the stage-one and
// output registers. The counts are updated and both stacks are read at the edge that
// takes a command; a stack write (insert or a cursor move) lands as stage one moves on
// and is forwarded to the read of the command behind it. The stacks are not cleared at
// reset and need no clearing pass, since only entries below the counts are ever used.
module cursor_text_buffer_unit #(
	parameter int CAPACITY = ctb_pkg::CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	ctb_cmd_if.sink       cmd,
	ctb_res_if.source     res
);

	localparam int AW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW     = $clog2(CAPACITY + 1);
	localparam int CMPW   = (CW > ctb_pkg::POS_W) ? CW : ctb_pkg::POS_W;
	localparam int LENXW  = (CW > ctb_pkg::LEN_W) ? CW : ctb_pkg::LEN_W;

	logic [ctb_pkg::CHAR_W-1:0] left_mem  [CAPACITY];
	logic [ctb_pkg::CHAR_W-1:0] right_mem [CAPACITY];

	logic [CW-1:0] left_count_q, right_count_q;

	// Stage one: the command after its counts update, with its pending stack write.
	logic                        valid_s1;
	ctb_pkg::opcode_t            op_s1;
	logic [ctb_pkg::CHAR_W-1:0]  char_s1;
	ctb_pkg::status_t            status_s1;
	logic [ctb_pkg::LEN_W-1:0]   len_s1, cur_s1;
	logic                        wr_left_s1, wr_right_s1;
	logic [AW-1:0]               waddr_s1;
	logic                        rd_hit_s1, rd_left_s1;
	logic [ctb_pkg::CHAR_W-1:0]  left_rd_s1, right_rd_s1;

	logic                        out_valid_q;
	logic [ctb_pkg::CHAR_W-1:0]  char_out_q;
	logic [ctb_pkg::STATUS_W-1:0] status_q;
	logic [ctb_pkg::LEN_W-1:0]   len_q, cur_q;

	logic                        go_s1, accept;
	logic                        wr_left, wr_right;
	logic [ctb_pkg::CHAR_W-1:0]  wdata;

	ctb_pkg::opcode_t            op;
	logic [CW-1:0]               total, lc_m1, rc_m1, lc_n, rc_n;
	logic [CMPW-1:0]             pos_ext, tot_ext, lc_ext, rpos;
	logic                        in_range, in_left;
	logic [AW-1:0]               raddr_l, raddr_r, waddr;
	logic                        wl, wr;
	ctb_pkg::status_t            status;
	logic [LENXW-1:0]            len_ext, cur_ext;

	assign go_s1     = !out_valid_q || res.ready;
	assign cmd.ready = !valid_s1 || go_s1;
	assign accept    = cmd.valid && cmd.ready;

	assign op      = ctb_pkg::opcode_t'(cmd.opcode);
	assign total   = left_count_q + right_count_q;
	assign lc_m1   = left_count_q - CW'(1);
	assign rc_m1   = right_count_q - CW'(1);
	assign pos_ext = CMPW'(cmd.position);
	assign tot_ext = CMPW'(total);
	assign lc_ext  = CMPW'(left_count_q);
	assign rpos    = tot_ext - pos_ext - CMPW'(1);
	assign in_range = pos_ext < tot_ext;
	assign in_left  = pos_ext < lc_ext;

	assign raddr_l = (op == ctb_pkg::OP_LEFT)  ? lc_m1[AW-1:0] : pos_ext[AW-1:0];
	assign raddr_r = (op == ctb_pkg::OP_RIGHT) ? rc_m1[AW-1:0] : rpos[AW-1:0];

	always_comb begin
		lc_n   = left_count_q;
		rc_n   = right_count_q;
		status = ctb_pkg::ST_DONE;
		wl     = 1'b0;
		wr     = 1'b0;
		waddr  = left_count_q[AW-1:0];
		case (op)
			ctb_pkg::OP_INSERT: begin
				if (total >= CW'(CAPACITY)) begin
					status = ctb_pkg::ST_FULL;
				end else begin
					wl   = 1'b1;
					lc_n = left_count_q + CW'(1);
				end
			end
			ctb_pkg::OP_LEFT: begin
				if (left_count_q == '0) begin
					status = ctb_pkg::ST_EDGE;
				end else begin
					wr    = 1'b1;
					waddr = right_count_q[AW-1:0];
					lc_n  = lc_m1;
					rc_n  = right_count_q + CW'(1);
				end
			end
			ctb_pkg::OP_RIGHT: begin
				if (right_count_q == '0) begin
					status = ctb_pkg::ST_EDGE;
				end else begin
					wl   = 1'b1;
					lc_n = left_count_q + CW'(1);
					rc_n = rc_m1;
				end
			end
			ctb_pkg::OP_BACK: begin
				if (left_count_q == '0) begin
					status = ctb_pkg::ST_EDGE;
				end else begin
					lc_n = lc_m1;
				end
			end
			ctb_pkg::OP_READ: begin
				if (!in_range) begin
					status = ctb_pkg::ST_RANGE;
				end
			end
			default: begin
				status = ctb_pkg::ST_EDGE;
			end
		endcase
	end

	assign len_ext = LENXW'(lc_n + rc_n);
	assign cur_ext = LENXW'(lc_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_count_q  <= '0;
			right_count_q <= '0;
		end else if (accept) begin
			left_count_q  <= lc_n;
			right_count_q <= rc_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= op;
			char_s1     <= cmd.char_in;
			status_s1   <= status;
			len_s1      <= len_ext[ctb_pkg::LEN_W-1:0];
			cur_s1      <= cur_ext[ctb_pkg::LEN_W-1:0];
			wr_left_s1  <= wl;
			wr_right_s1 <= wr;
			waddr_s1    <= waddr;
			rd_hit_s1   <= (op == ctb_pkg::OP_READ) && in_range;
			rd_left_s1  <= in_left;
		end
	end

	// The pending write retires as stage one moves on; a moved character comes from
	// the other stack's read data taken when the command was accepted.
	assign wr_left  = valid_s1 && go_s1 && wr_left_s1;
	assign wr_right = valid_s1 && go_s1 && wr_right_s1;
	assign wdata    = (op_s1 == ctb_pkg::OP_RIGHT) ? right_rd_s1 :
	                  (op_s1 == ctb_pkg::OP_LEFT)  ? left_rd_s1  : char_s1;

	always_ff @(posedge clk) begin
		if (wr_left) begin
			left_mem[waddr_s1] <= wdata;
		end
		if (accept) begin
			left_rd_s1 <= (wr_left && waddr_s1 == raddr_l) ? wdata : left_mem[raddr_l];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_right) begin
			right_mem[waddr_s1] <= wdata;
		end
		if (accept) begin
			right_rd_s1 <= (wr_right && waddr_s1 == raddr_r) ? wdata : right_mem[raddr_r];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && go_s1) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && go_s1) begin
			if (rd_hit_s1) begin
				char_out_q <= rd_left_s1 ? left_rd_s1 : right_rd_s1;
			end else begin
				char_out_q <= '0;
			end
			status_q <= status_s1;
			len_q    <= len_s1;
			cur_q    <= cur_s1;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.char_out     = char_out_q;
	assign res.status       = status_q;
	assign res.text_length  = len_q;
	assign res.cursor_index = cur_q;

endmodule
